@@ design/pidc_pkg.sv @@
// Shared types and constants for the incremental PID controller.
package pidc_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int OUT_FRAC_BITS      = 8;
	localparam int PERIOD_FRAC_BITS   = 16;
	localparam int GAIN_W             = 16;
	localparam int KIP_W              = 2 * GAIN_W;
	localparam int OUT_W              = 32;
	localparam int LIMIT_W            = 31;
	localparam int CFG_IDX_W          = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP     = 3'd0,
		CFG_KI     = 3'd1,
		CFG_KD     = 3'd2,
		CFG_PERIOD = 3'd3,
		CFG_LIMIT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KIP,
		ST_LO,
		ST_HI,
		ST_P,
		ST_D,
		ST_ACC,
		ST_SCALE,
		ST_SAT
	} state_t;

	typedef enum logic [2:0] {
		MUL_KIP,
		MUL_LO,
		MUL_HI,
		MUL_P,
		MUL_D
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_SET_LO,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     kip_load;
		logic     prod_load;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     tot_load;
		logic     commit;
	} pidc_cmd_t;

	typedef struct packed {
		logic out_busy;
	} pidc_status_t;

endpackage

@@ design/pidc_ctrl.sv @@
// Sequencer that steps one item through the shared multiplier and the output stage.
module pidc_ctrl import pidc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         enable,
	input  pidc_status_t status,
	output logic         in_stall,
	output pidc_cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = enable ? ST_KIP : ST_SAT;
				end
			end
			ST_KIP:   state_next = ST_LO;
			ST_LO:    state_next = ST_HI;
			ST_HI:    state_next = ST_P;
			ST_P:     state_next = ST_D;
			ST_D:     state_next = ST_ACC;
			ST_ACC:   state_next = ST_SCALE;
			ST_SCALE: state_next = ST_SAT;
			ST_SAT: begin
				if (!status.out_busy) begin
					state_next = ST_IDLE;
				end
			end
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		cmd.load      = 1'b0;
		cmd.kip_load  = 1'b0;
		cmd.prod_load = 1'b0;
		cmd.mul_sel   = MUL_P;
		cmd.acc_op    = ACC_HOLD;
		cmd.tot_load  = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_KIP: begin
				cmd.mul_sel  = MUL_KIP;
				cmd.kip_load = 1'b1;
			end
			ST_LO: begin
				cmd.mul_sel   = MUL_LO;
				cmd.prod_load = 1'b1;
			end
			ST_HI: begin
				cmd.mul_sel   = MUL_HI;
				cmd.prod_load = 1'b1;
				cmd.acc_op    = ACC_SET_LO;
			end
			ST_P: begin
				cmd.mul_sel   = MUL_P;
				cmd.prod_load = 1'b1;
				cmd.acc_op    = ACC_ADD;
			end
			ST_D: begin
				cmd.mul_sel   = MUL_D;
				cmd.prod_load = 1'b1;
				cmd.acc_op    = ACC_ADD;
			end
			ST_ACC: begin
				cmd.acc_op = ACC_ADD;
			end
			ST_SCALE: begin
				cmd.tot_load = 1'b1;
			end
			ST_SAT: begin
				cmd.commit = !status.out_busy;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ design/pidc_datapath.sv @@
// Error history, shared multiplier, accumulator, saturation and output register.
module pidc_datapath import pidc_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pidc_cmd_t                      cmd,
	output pidc_status_t                   status,
	input  logic                           enable,
	input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0] feedback,
	input  logic [GAIN_W-1:0]              kp_gain,
	input  logic [GAIN_W-1:0]              ki_gain,
	input  logic [GAIN_W-1:0]              kd_gain,
	input  logic [GAIN_W-1:0]              sample_period,
	input  logic [LIMIT_W-1:0]             output_limit,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [OUT_W-1:0]        control_output
);

	localparam int EW     = SAMPLE_WIDTH + 1;
	localparam int MA     = (SAMPLE_WIDTH + 3 > GAIN_W + 1) ? SAMPLE_WIDTH + 3 : GAIN_W + 1;
	localparam int PW     = MA + GAIN_W + 1;
	localparam int ACC_W  = MA + 21;
	localparam int SHR    = (GAIN_FRAC_BITS >= OUT_FRAC_BITS) ? GAIN_FRAC_BITS - OUT_FRAC_BITS : 0;
	localparam int SHL    = (GAIN_FRAC_BITS < OUT_FRAC_BITS) ? OUT_FRAC_BITS - GAIN_FRAC_BITS : 0;
	localparam int TOT_W  = ACC_W + SHL + 1;

	logic signed [EW-1:0]    e1_q;
	logic signed [EW-1:0]    e0_q;
	logic signed [EW-1:0]    err_q;
	logic signed [EW:0]      dp_q;
	logic signed [EW+1:0]    dd_q;
	logic                    en_q;
	logic [KIP_W-1:0]        kip_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [TOT_W-1:0] tot_q;
	logic signed [OUT_W-1:0] accum_q;
	logic signed [OUT_W-1:0] out_q;
	logic                    out_valid_q;

	logic signed [EW-1:0]    err_w;
	logic signed [EW:0]      dp_w;
	logic signed [EW+1:0]    dd_w;
	logic signed [MA-1:0]    mul_a;
	logic signed [GAIN_W:0]  mul_b;
	logic signed [PW-1:0]    prod_w;
	logic signed [PW-1:0]    lo_sh;
	logic signed [TOT_W-1:0] acc_ext;
	logic signed [TOT_W-1:0] scaled;
	logic signed [TOT_W-1:0] lim_pos;
	logic signed [TOT_W-1:0] lim_neg;
	logic signed [TOT_W-1:0] sat;
	logic signed [OUT_W-1:0] result;
	logic                    out_taken;

	always_comb begin
		if (enable) begin
			err_w = EW'(setpoint) - EW'(feedback);
		end else begin
			err_w = '0;
		end
		dp_w = (EW+1)'(err_w) - (EW+1)'(e1_q);
		dd_w = (EW+2)'(err_w) - ((EW+2)'(e1_q) <<< 1) + (EW+2)'(e0_q);
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_KIP: begin
				mul_a = signed'(MA'(ki_gain));
				mul_b = signed'({1'b0, sample_period});
			end
			MUL_LO: begin
				mul_a = MA'(err_q);
				mul_b = signed'({1'b0, kip_q[GAIN_W-1:0]});
			end
			MUL_HI: begin
				mul_a = MA'(err_q);
				mul_b = signed'({1'b0, kip_q[KIP_W-1:GAIN_W]});
			end
			MUL_P: begin
				mul_a = MA'(dp_q);
				mul_b = signed'({1'b0, kp_gain});
			end
			MUL_D: begin
				mul_a = MA'(dd_q);
				mul_b = signed'({1'b0, kd_gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_w = PW'(mul_a) * PW'(mul_b);
		lo_sh  = prod_q >>> PERIOD_FRAC_BITS;
	end

	always_comb begin
		acc_ext = TOT_W'(acc_q);
		if (GAIN_FRAC_BITS >= OUT_FRAC_BITS) begin
			scaled = acc_ext >>> SHR;
		end else begin
			scaled = acc_ext <<< SHL;
		end
		lim_pos = signed'(TOT_W'(output_limit));
		lim_neg = -lim_pos;
		if (tot_q > lim_pos) begin
			sat = lim_pos;
		end else if (tot_q < lim_neg) begin
			sat = lim_neg;
		end else begin
			sat = tot_q;
		end
		result    = en_q ? sat[OUT_W-1:0] : '0;
		out_taken = out_valid_q && !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= err_w;
			dp_q  <= dp_w;
			dd_q  <= dd_w;
			en_q  <= enable;
		end
		if (cmd.kip_load) begin
			kip_q <= prod_w[KIP_W-1:0];
		end
		if (cmd.prod_load) begin
			prod_q <= prod_w;
		end
		case (cmd.acc_op)
			ACC_SET_LO: acc_q <= ACC_W'(lo_sh);
			ACC_ADD:    acc_q <= acc_q + ACC_W'(prod_q);
			default:    acc_q <= acc_q;
		endcase
		if (cmd.tot_load) begin
			tot_q <= scaled + TOT_W'(accum_q);
		end
		if (cmd.commit) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q        <= '0;
			e0_q        <= '0;
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				e0_q        <= e1_q;
				e1_q        <= err_q;
				accum_q     <= result;
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign control_output  = out_q;

endmodule

@@ design/incremental_pid_controller.sv @@
// Incremental PID controller top level with configuration registers.
//
// Input channel: enable, setpoint and feedback move on a transfer when in_valid is
// high and in_stall is low. Output channel: control_output moves on a transfer
// when out_valid is high and out_stall is low. Every input item gives one result.
// Gains, sample period and output limit are written through cfg_we, cfg_index and
// cfg_wdata; writes to unknown indexes are ignored. The user must write them only
// while the block is idle; the block itself does not enforce this. For an enabled
// item, one shared multiplier forms ki*period, the two halves of the integral
// term, the proportional and the derivative terms in turn, then the accumulator
// adds the last product, the scale step scales it and adds the running output
// and the saturation step saturates it. A disabled item goes straight to the
// saturation step and gives a zero result. The block takes one item at a time,
// so the next item is accepted in the cycle after the previous result is registered.
// The result sits in an output register; while the receiver stalls, the block
// still accepts and works on the next item and holds it at the saturation step
// until the register frees up.
// Reset clears the error history, the running output and the gains and period,
// and sets the output limit to its maximum.
module incremental_pid_controller import pidc_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [LIMIT_W-1:0]             cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           enable,
	input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0] feedback,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [OUT_W-1:0]        control_output
);

	logic [GAIN_W-1:0]  kp_q;
	logic [GAIN_W-1:0]  ki_q;
	logic [GAIN_W-1:0]  kd_q;
	logic [GAIN_W-1:0]  period_q;
	logic [LIMIT_W-1:0] limit_q;

	pidc_cmd_t    cmd;
	pidc_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			period_q <= '0;
			limit_q  <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KP:     kp_q     <= cfg_wdata[GAIN_W-1:0];
				CFG_KI:     ki_q     <= cfg_wdata[GAIN_W-1:0];
				CFG_KD:     kd_q     <= cfg_wdata[GAIN_W-1:0];
				CFG_PERIOD: period_q <= cfg_wdata[GAIN_W-1:0];
				CFG_LIMIT:  limit_q  <= cfg_wdata;
				default:    limit_q  <= limit_q;
			endcase
		end
	end

	pidc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.enable   (enable),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	pidc_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.enable         (enable),
		.setpoint       (setpoint),
		.feedback       (feedback),
		.kp_gain        (kp_q),
		.ki_gain        (ki_q),
		.kd_gain        (kd_q),
		.sample_period  (period_q),
		.output_limit   (limit_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.control_output (control_output)
	);

endmodule
